// ===== rtl/core/tsut_pkg.sv =====
// Package for the Taylor series sine block: sizes, fixed-point constants,
// sequencer states and the divider status struct.
// No dependencies.
`timescale 1ns / 1ps

package tsut_pkg;

  localparam int MAX_ANGLE = 16;
  localparam int FRAC_BITS = 32;
  localparam int MAX_TERMS = 32;

  localparam int ANGLE_W = 6;                        // input angle field
  localparam int AX_W    = $clog2(MAX_ANGLE + 1);    // magnitude of clamped angle
  localparam int X2_W    = 2 * AX_W;                 // angle squared
  localparam int MAG_W   = 63;                       // unsigned term magnitude
  localparam int SUM_W   = 64;                       // signed Q31.32 sum
  localparam int PROD_W  = MAG_W + X2_W;             // term times angle squared
  localparam int TOL_W   = 32;
  localparam int CNT_W   = $clog2(MAX_TERMS + 1);    // term counter
  localparam int OCNT_W  = 6;                        // term_count field
  localparam int D_W     = $clog2(2 * MAX_TERMS + 2);// denominator factor
  localparam int DIV_W   = 2 * D_W;                  // d1 * d2
  localparam int DSTEP_W = $clog2(MAG_W);            // divider step counter

  // The Q0.32 tolerance is aligned to FRAC_BITS by one of these shifts.
  localparam int TOL_SHL = (FRAC_BITS > TOL_W) ? FRAC_BITS - TOL_W : 0;
  localparam int TOL_SHR = (FRAC_BITS < TOL_W) ? TOL_W - FRAC_BITS : 0;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(4294967);
  localparam logic [MAG_W-1:0] MAG_MAX   = {MAG_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/core/tsut_div.sv =====
// Serial restoring divider for the sine block: one quotient bit per cycle.
// Depends on tsut_pkg for widths and the status struct.
`timescale 1ns / 1ps

module tsut_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tsut_pkg::MAG_W-1:0]  dividend,
  input  logic [tsut_pkg::DIV_W-1:0]  divisor,
  output logic [tsut_pkg::MAG_W-1:0]  quotient,
  output tsut_pkg::div_status_t       status
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [tsut_pkg::DSTEP_W-1:0]  cnt_r, cnt_nxt;
  logic [tsut_pkg::MAG_W-1:0]    quo_r, quo_nxt;
  logic [tsut_pkg::DIV_W:0]      rem_r, rem_nxt;
  logic [tsut_pkg::DIV_W-1:0]    dvs_r, dvs_nxt;
  logic [tsut_pkg::DIV_W:0]      rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r[tsut_pkg::DIV_W-1:0], quo_r[tsut_pkg::MAG_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = tsut_pkg::DSTEP_W'(tsut_pkg::MAG_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[tsut_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[tsut_pkg::MAG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// ===== rtl/core/taylor_sine_until_tolerance.sv =====
// Top level of the Taylor series sine block: sequencer, term datapath and ports.
// Depends on tsut_pkg and tsut_div.
`timescale 1ns / 1ps

// Usage:
// An angle in whole radians arrives on the in_ channel (valid/ready). The
// block clamps it to +/-16, then sums the Maclaurin series of sine in signed
// Q31.32 until the magnitude of the latest term no longer exceeds the
// tolerance register, or until 32 terms have been summed (limit_reached).
// Each added term passes through ST_CHECK, ST_MUL, ST_DIV_START, ST_DIV_WAIT
// and ST_ACC: a multiply by the angle squared, then a serial divide by d1*d2.
// The serial divider sets the time taken per term.
// in_ready is high only while the sequencer is idle; one item is worked on at
// a time. The result sits in an output register, so a new transfer is taken
// while the previous result still waits on a stalled receiver; the sequencer
// holds the finished result until that register is free.
// The cfg_ channel writes the tolerance (unsigned Q0.32) and is always ready;
// write it only while the block is idle. Reset loads the tolerance with about
// 0.001 and drops all valid flags.
module taylor_sine_until_tolerance (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [tsut_pkg::ANGLE_W-1:0] in_angle,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tsut_pkg::SUM_W-1:0] out_sine_value,
  output logic [tsut_pkg::OCNT_W-1:0]       out_term_count,
  output logic                              out_limit_reached,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tsut_pkg::TOL_W-1:0]        cfg_data
);

  tsut_pkg::state_t                  state_r, state_nxt;
  logic [tsut_pkg::TOL_W-1:0]        tol_r, tol_nxt;
  logic [tsut_pkg::X2_W-1:0]         x2_r, x2_nxt;
  logic [tsut_pkg::MAG_W-1:0]        mag_r, mag_nxt;
  logic                              neg_r, neg_nxt;
  logic signed [tsut_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [tsut_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [tsut_pkg::D_W-1:0]          d1_r, d1_nxt, d2_r, d2_nxt;
  logic [tsut_pkg::DIV_W-1:0]        dvs_r, dvs_nxt;
  logic                              lim_r, lim_nxt;
  logic                              ovld_r, ovld_nxt;
  logic signed [tsut_pkg::SUM_W-1:0] osum_r, osum_nxt;
  logic [tsut_pkg::OCNT_W-1:0]       ocnt_r, ocnt_nxt;
  logic                              olim_r, olim_nxt;

  logic signed [tsut_pkg::ANGLE_W-1:0] ang_clamp;
  logic signed [tsut_pkg::ANGLE_W-1:0] ang_abs;
  logic [tsut_pkg::AX_W-1:0]           ax;
  logic [tsut_pkg::MAG_W-1:0]          mag_init;
  logic [tsut_pkg::MAG_W-1:0]          tol_al;
  logic [tsut_pkg::PROD_W-1:0]         prod;
  logic signed [tsut_pkg::SUM_W-1:0]   term_init;
  logic signed [tsut_pkg::SUM_W-1:0]   term_acc;
  logic signed [tsut_pkg::SUM_W:0]     sum_wide;
  logic                                div_start;
  logic [tsut_pkg::MAG_W-1:0]          div_quo;
  tsut_pkg::div_status_t               div_st;

  tsut_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_r),
    .divisor  (dvs_r),
    .quotient (div_quo),
    .status   (div_st)
  );

  // Angle clamp and magnitude of the first term.
  always_comb begin
    if (in_angle > tsut_pkg::ANGLE_W'(tsut_pkg::MAX_ANGLE)) begin
      ang_clamp = tsut_pkg::ANGLE_W'(tsut_pkg::MAX_ANGLE);
    end else if (in_angle < -tsut_pkg::ANGLE_W'(tsut_pkg::MAX_ANGLE)) begin
      ang_clamp = -tsut_pkg::ANGLE_W'(tsut_pkg::MAX_ANGLE);
    end else begin
      ang_clamp = in_angle;
    end
    ang_abs   = ang_clamp[tsut_pkg::ANGLE_W-1] ? -ang_clamp : ang_clamp;
    ax        = ang_abs[tsut_pkg::AX_W-1:0];
    mag_init  = tsut_pkg::MAG_W'(ax) << tsut_pkg::FRAC_BITS;
    term_init = ang_clamp[tsut_pkg::ANGLE_W-1] ? -$signed({1'b0, mag_init})
                                               : $signed({1'b0, mag_init});
  end

  assign tol_al   = (tsut_pkg::MAG_W'(tol_r) << tsut_pkg::TOL_SHL) >> tsut_pkg::TOL_SHR;
  assign prod     = tsut_pkg::PROD_W'(mag_r) * tsut_pkg::PROD_W'(x2_r);
  assign term_acc = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
  assign sum_wide = {sum_r[tsut_pkg::SUM_W-1], sum_r}
                  + {term_acc[tsut_pkg::SUM_W-1], term_acc};

  always_comb begin
    state_nxt = state_r;
    tol_nxt   = tol_r;
    x2_nxt    = x2_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    d1_nxt    = d1_r;
    d2_nxt    = d2_r;
    dvs_nxt   = dvs_r;
    lim_nxt   = lim_r;
    ovld_nxt  = ovld_r;
    osum_nxt  = osum_r;
    ocnt_nxt  = ocnt_r;
    olim_nxt  = olim_r;
    div_start = 1'b0;

    if (cfg_valid) begin
      tol_nxt = cfg_data;
    end
    if (ovld_r && out_ready) begin
      ovld_nxt = 1'b0;
    end

    unique case (state_r)
      tsut_pkg::ST_IDLE: begin
        if (in_valid) begin
          x2_nxt    = tsut_pkg::X2_W'(ax) * tsut_pkg::X2_W'(ax);
          mag_nxt   = mag_init;
          neg_nxt   = ang_clamp[tsut_pkg::ANGLE_W-1];
          sum_nxt   = term_init;
          cnt_nxt   = tsut_pkg::CNT_W'(1);
          d1_nxt    = tsut_pkg::D_W'(2);
          d2_nxt    = tsut_pkg::D_W'(3);
          lim_nxt   = 1'b0;
          state_nxt = tsut_pkg::ST_CHECK;
        end
      end
      tsut_pkg::ST_CHECK: begin
        if (mag_r > tol_al) begin
          if (cnt_r >= tsut_pkg::CNT_W'(tsut_pkg::MAX_TERMS)) begin
            lim_nxt   = 1'b1;
            state_nxt = tsut_pkg::ST_OUT;
          end else begin
            state_nxt = tsut_pkg::ST_MUL;
          end
        end else begin
          state_nxt = tsut_pkg::ST_OUT;
        end
      end
      tsut_pkg::ST_MUL: begin
        // The product saturates at the largest term magnitude.
        if (prod[tsut_pkg::PROD_W-1:tsut_pkg::MAG_W] != '0) begin
          mag_nxt = tsut_pkg::MAG_MAX;
        end else begin
          mag_nxt = prod[tsut_pkg::MAG_W-1:0];
        end
        dvs_nxt   = tsut_pkg::DIV_W'(d1_r) * tsut_pkg::DIV_W'(d2_r);
        state_nxt = tsut_pkg::ST_DIV_START;
      end
      tsut_pkg::ST_DIV_START: begin
        div_start = 1'b1;
        state_nxt = tsut_pkg::ST_DIV_WAIT;
      end
      tsut_pkg::ST_DIV_WAIT: begin
        if (div_st.done) begin
          mag_nxt   = div_quo;
          neg_nxt   = !neg_r;
          state_nxt = tsut_pkg::ST_ACC;
        end
      end
      tsut_pkg::ST_ACC: begin
        if (sum_wide[tsut_pkg::SUM_W] != sum_wide[tsut_pkg::SUM_W-1]) begin
          sum_nxt = sum_wide[tsut_pkg::SUM_W]
                  ? {1'b1, {(tsut_pkg::SUM_W-1){1'b0}}}
                  : {1'b0, {(tsut_pkg::SUM_W-1){1'b1}}};
        end else begin
          sum_nxt = sum_wide[tsut_pkg::SUM_W-1:0];
        end
        cnt_nxt   = cnt_r + 1'b1;
        d1_nxt    = d1_r + tsut_pkg::D_W'(2);
        d2_nxt    = d2_r + tsut_pkg::D_W'(2);
        state_nxt = tsut_pkg::ST_CHECK;
      end
      tsut_pkg::ST_OUT: begin
        // Wait until the output register is free or being emptied.
        if (!ovld_r || out_ready) begin
          ovld_nxt  = 1'b1;
          osum_nxt  = sum_r;
          ocnt_nxt  = tsut_pkg::OCNT_W'(cnt_r);
          olim_nxt  = lim_r;
          state_nxt = tsut_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tsut_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsut_pkg::ST_IDLE;
      tol_r   <= tsut_pkg::TOL_RESET;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tol_r   <= tol_nxt;
      ovld_r  <= ovld_nxt;
    end
    x2_r   <= x2_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    sum_r  <= sum_nxt;
    cnt_r  <= cnt_nxt;
    d1_r   <= d1_nxt;
    d2_r   <= d2_nxt;
    dvs_r  <= dvs_nxt;
    lim_r  <= lim_nxt;
    osum_r <= osum_nxt;
    ocnt_r <= ocnt_nxt;
    olim_r <= olim_nxt;
  end

  assign in_ready          = (state_r == tsut_pkg::ST_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = ovld_r;
  assign out_sine_value    = osum_r;
  assign out_term_count    = ocnt_r;
  assign out_limit_reached = olim_r;

  // A result always counts the first term.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_term_count != '0))
    else $error("result with zero term count");

  // The limit flag only comes with a full term count.
  a_limit_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_limit_reached) |->
      (out_term_count == tsut_pkg::OCNT_W'(tsut_pkg::MAX_TERMS)))
    else $error("limit flag without full term count");

  // After an input transfer the block is busy.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after an input transfer");

  // The divider finishes only while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == tsut_pkg::ST_DIV_WAIT))
    else $error("divider done outside its wait state");

endmodule
